[design/serial_frame_receiver_assert.svh]
// Assertion macros for the serial frame receiver checks.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sfr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sfr check failed");

`endif

[design/sfr_pkg.sv]
// Types, constants and CRC function for the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned PayloadDepth = 32;
  localparam int unsigned AddrW        = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 6;
  localparam int unsigned ByteIdxW  = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [ByteW-1:0] CrcPoly = 8'h07;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;
  localparam logic [ByteW-1:0] CrcMsb  = 8'h80;

  localparam logic [ByteW-1:0] SyncFirstReset  = 8'd170;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'd85;
  localparam logic [LenW-1:0]  MaxLengthReset  = 6'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LENGTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_TYPE,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_READ,
    ST_LOAD
  } rx_state_e;

  // CRC-8, MSB first, one byte absorbed
  function automatic logic [ByteW-1:0] crc8_absorb(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if ((c & CrcMsb) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[design/sfr_if.sv]
// Handshake channel interfaces: received bytes, frame results, register writes.
`timescale 1ns / 1ps

interface sfr_rx_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_frame_if;
  import sfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ByteW-1:0]    frame_type;
  logic [LenW-1:0]     frame_length;
  logic [ByteIdxW-1:0] byte_index;
  logic [ByteW-1:0]    payload_byte;
  logic                last_byte;
  modport source (output valid, output frame_type, output frame_length, output byte_index,
                  output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_type, input frame_length, input byte_index,
                  input payload_byte, input last_byte, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/serial_frame_receiver.sv]
// Serial frame receiver: sync hunt, header parse, CRC-8 check and payload replay.
// Usage:
//   rx_i    : one received byte per beat. Taken one per cycle while a frame is being
//             parsed; held off (ready low) while an accepted frame is replayed.
//   frame_o : one beat per payload byte of a frame whose CRC matched, or a single
//             beat with zero payload for an empty frame; last_byte marks the end.
//   cfg_i   : register writes (sync_first, sync_second, max_length); always ready.
// After the CRC byte is taken, each result is made by ST_READ (payload RAM read)
//   then ST_LOAD (output register load); the load waits while the output is full.
// Throughput: parsing runs at 1 byte per cycle; rx_i stays stalled during replay
//   until the output register has loaded the last result of the frame.
// Reset: registers return to 0xAA / 0x55 / 32, hunting for the first sync byte.
//   The payload RAM is not cleared; only entries written by the current frame
//   are read back.
// Output stall: a result waits in the output register; replay pauses until it
//   is taken. The last result may wait while parsing of the next frame begins.
`timescale 1ns / 1ps

module serial_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfr_rx_if.sink      rx_i,
  sfr_frame_if.source frame_o,
  sfr_cfg_if.sink     cfg_i
);
  import sfr_pkg::*;

  rx_state_e state_q, state_d;

  logic [ByteW-1:0] sync_first_q, sync_second_q;
  logic [LenW-1:0]  max_length_q;

  logic [ByteW-1:0] held_type_q, held_type_d;
  logic [LenW-1:0]  held_length_q, held_length_d;
  logic [LenW-1:0]  fill_count_q, fill_count_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [LenW-1:0]  emit_idx_q, emit_idx_d;

  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_type_q;
  logic [LenW-1:0]     out_length_q;
  logic [ByteIdxW-1:0] out_index_q;
  logic [ByteW-1:0]    out_payload_q;
  logic                out_last_q;

  logic [ByteW-1:0] payload_mem [PayloadDepth];
  logic [ByteW-1:0] rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic             mem_we;

  logic             rx_ready;
  logic             rx_fire;
  logic [ByteW-1:0] rx_b;
  logic [ByteW-1:0] crc_next;
  logic [ByteW-1:0] limit;
  logic             too_long;
  logic             data_done;
  logic             emit_last;
  logic             out_free;
  logic             load_out;

  assign rx_b      = rx_i.rx_byte;
  assign rx_fire   = rx_i.valid && rx_ready;
  assign rx_i.ready = rx_ready;
  assign cfg_i.ready = 1'b1;

  assign crc_next  = crc8_absorb((state_q == ST_TYPE) ? CrcInit : crc_q, rx_b);
  assign limit     = ({2'b00, max_length_q} > ByteW'(PayloadDepth)) ?
                     ByteW'(PayloadDepth) : {2'b00, max_length_q};
  assign too_long  = rx_b > limit;
  assign data_done = (fill_count_q + LenW'(1)) >= held_length_q;
  assign emit_last = ({1'b0, emit_idx_q} + (LenW+1)'(1)) >= {1'b0, held_length_q};
  assign out_free  = !out_valid_q || frame_o.ready;
  assign rd_addr   = emit_idx_q[AddrW-1:0];
  assign wr_addr   = fill_count_q[AddrW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SYNC1: if (rx_fire && rx_b == sync_first_q) state_d = ST_SYNC2;
      ST_SYNC2: if (rx_fire) state_d = (rx_b == sync_second_q) ? ST_TYPE : ST_SYNC1;
      ST_TYPE:  if (rx_fire) state_d = ST_LEN;
      ST_LEN: begin
        if (rx_fire) begin
          priority if (too_long) state_d = ST_SYNC1;
          else if (rx_b == '0)   state_d = ST_CHECK;
          else                   state_d = ST_DATA;
        end
      end
      ST_DATA:  if (rx_fire && data_done) state_d = ST_CHECK;
      ST_CHECK: if (rx_fire) state_d = (crc_q == rx_b) ? ST_READ : ST_SYNC1;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  if (out_free) state_d = emit_last ? ST_SYNC1 : ST_READ;
    endcase
  end

  // control outputs
  always_comb begin
    rx_ready = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_SYNC1, ST_SYNC2, ST_TYPE, ST_LEN, ST_CHECK: rx_ready = 1'b1;
      ST_DATA: begin
        rx_ready = 1'b1;
        mem_we   = rx_i.valid && (32'(fill_count_q) < PayloadDepth);
      end
      ST_READ: rx_ready = 1'b0;
      ST_LOAD: load_out = out_free;
    endcase
  end

  // datapath next values
  always_comb begin
    held_type_d   = held_type_q;
    held_length_d = held_length_q;
    fill_count_d  = fill_count_q;
    crc_d         = crc_q;
    emit_idx_d    = emit_idx_q;
    out_valid_d   = out_valid_q;
    if (out_valid_q && frame_o.ready) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      emit_idx_d  = emit_idx_q + LenW'(1);
    end
    if (rx_fire) begin
      unique case (state_q)
        ST_TYPE: begin
          held_type_d = rx_b;
          crc_d       = crc_next;
        end
        ST_LEN: begin
          fill_count_d = '0;
          if (!too_long) begin
            held_length_d = rx_b[LenW-1:0];
            crc_d         = crc_next;
          end
        end
        ST_DATA: begin
          fill_count_d = fill_count_q + LenW'(1);
          crc_d        = crc_next;
        end
        ST_CHECK: emit_idx_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SYNC1;
      held_type_q   <= '0;
      held_length_q <= '0;
      fill_count_q  <= '0;
      crc_q         <= CrcInit;
      emit_idx_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      held_type_q   <= held_type_d;
      held_length_q <= held_length_d;
      fill_count_q  <= fill_count_d;
      crc_q         <= crc_d;
      emit_idx_q    <= emit_idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
      max_length_q  <= MaxLengthReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_i.data;
        CFG_SYNC_SECOND: sync_second_q <= cfg_i.data;
        CFG_MAX_LENGTH:  max_length_q  <= cfg_i.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // payload RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) payload_mem[wr_addr] <= rx_b;
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= payload_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_type_q    <= held_type_q;
      out_length_q  <= held_length_q;
      out_index_q   <= emit_idx_q[ByteIdxW-1:0];
      out_payload_q <= (held_length_q == '0) ? '0 : rd_data_q;
      out_last_q    <= emit_last;
    end
  end

  assign frame_o.valid        = out_valid_q;
  assign frame_o.frame_type   = out_type_q;
  assign frame_o.frame_length = out_length_q;
  assign frame_o.byte_index   = out_index_q;
  assign frame_o.payload_byte = out_payload_q;
  assign frame_o.last_byte    = out_last_q;

endmodule

[design/sfr_checker.sv]
// Port-level checks for the serial frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "serial_frame_receiver_assert.svh"

module sfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rx_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sfr_pkg::ByteW-1:0]    frame_type_i,
  input logic [sfr_pkg::LenW-1:0]     frame_length_i,
  input logic [sfr_pkg::ByteIdxW-1:0] byte_index_i,
  input logic [sfr_pkg::ByteW-1:0]    payload_byte_i,
  input logic                         last_byte_i
);
  import sfr_pkg::*;

  logic [LenW-1:0] index_plus_one;
  assign index_plus_one = LenW'(byte_index_i) + LenW'(1);

  // input is held off while a frame is still being replayed
  `SFR_ASSERT_IMP(a_replay_blocks_rx, clk_i, rst_ni,
    out_valid_i && !last_byte_i, !rx_ready_i)

  `SFR_ASSERT_IMP(a_empty_frame_beat, clk_i, rst_ni,
    out_valid_i && frame_length_i == '0,
    last_byte_i && byte_index_i == '0 && payload_byte_i == '0)

  `SFR_ASSERT_IMP(a_last_matches_length, clk_i, rst_ni,
    out_valid_i && frame_length_i != '0, last_byte_i == (index_plus_one == frame_length_i))

  `SFR_ASSERT_NXT(a_stalled_beat_holds, clk_i, rst_ni,
    out_valid_i && !out_ready_i,
    out_valid_i && $stable(frame_type_i) && $stable(frame_length_i) &&
    $stable(byte_index_i) && $stable(payload_byte_i) && $stable(last_byte_i))

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_ready_i     (rx_i.ready),
  .out_valid_i    (frame_o.valid),
  .out_ready_i    (frame_o.ready),
  .frame_type_i   (frame_o.frame_type),
  .frame_length_i (frame_o.frame_length),
  .byte_index_i   (frame_o.byte_index),
  .payload_byte_i (frame_o.payload_byte),
  .last_byte_i    (frame_o.last_byte)
);

[tb/serial_frame_receiver_tb.sv]
// Self-checking testbench for the serial frame receiver: frame predictor, result queue, stimulus.
`timescale 1ns / 1ps

module serial_frame_receiver_tb;
  import sfr_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0]    ftype;
    logic [LenW-1:0]     flen;
    logic [ByteIdxW-1:0] idx;
    logic [ByteW-1:0]    pbyte;
    logic                last;
  } frame_beat_t;

  typedef enum logic [1:0] {BYTE_RAW, BYTE_CRC_OK, BYTE_CRC_BAD} rx_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] value;
    rx_kind_e         kind;
    logic             typed;
    frame_beat_t      beat;
  } dir_row_t;

  localparam frame_beat_t NO_BEAT   = '0;
  localparam int          HOLD_CYC  = 600;
  localparam int          NUM_DIR   = 25;

  // Reset settings: sync 0xAA 0x55, max length 32
  localparam dir_row_t DIRECTED_ROWS [NUM_DIR] = '{
    '{8'h00, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'hAA, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h55, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h00, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h00, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h00, BYTE_RAW,     1'b1, '{8'h00, 6'd0, 5'd0, 8'h00, 1'b1}},
    // wrong second sync; the repeated 0xAA must not restart the hunt
    '{8'hAA, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'hAA, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h55, BYTE_RAW,     1'b0, NO_BEAT},
    // length 33, above the limit
    '{8'hAA, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h55, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'hFF, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h21, BYTE_RAW,     1'b0, NO_BEAT},
    // CRC mismatch, dropped
    '{8'hAA, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h55, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'hFF, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h01, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'hFF, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h00, BYTE_CRC_BAD, 1'b0, NO_BEAT},
    '{8'hAA, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h55, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'hFF, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h01, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h80, BYTE_RAW,     1'b0, NO_BEAT},
    '{8'h00, BYTE_CRC_OK,  1'b1, '{8'hFF, 6'd1, 5'd0, 8'h80, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  sfr_rx_if    rx_ch ();
  sfr_frame_if frame_ch ();
  sfr_cfg_if   cfg_ch ();

  serial_frame_receiver dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_ch),
    .frame_o (frame_ch),
    .cfg_i   (cfg_ch)
  );

  // predictor state and register copies
  rx_state_e        parse_phase;
  logic [ByteW-1:0] sync_first_r;
  logic [ByteW-1:0] sync_second_r;
  logic [LenW-1:0]  max_len_r;
  logic [ByteW-1:0] held_type;
  logic [LenW-1:0]  held_len;
  logic [LenW-1:0]  fill;
  logic [ByteW-1:0] run_crc;
  logic [ByteW-1:0] payload_mem [PayloadDepth];

  frame_beat_t fresh_beats[$];
  frame_beat_t expected_beats[$];

  int  tx_calm, rx_calm;
  int  rx_bytes_sent, framed_bytes, beats_checked, frames_seen, bad_beats, holds_done;
  bit  hold_sink_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [ByteW-1:0] crc_next(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] d);
    logic [ByteW-1:0] c;
    c = crc ^ d;
    for (int k = 0; k < ByteW; k++) begin
      c = c[ByteW-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Advance the parser copy by one byte; beats of a good frame land in fresh_beats
  function automatic void absorb_rx_byte(input logic [ByteW-1:0] b);
    int unsigned lim;
    frame_beat_t nb;
    fresh_beats.delete();
    case (parse_phase)
      ST_SYNC2: begin
        parse_phase = (b == sync_second_r) ? ST_TYPE : ST_SYNC1;
      end
      ST_TYPE: begin
        held_type   = b;
        run_crc     = crc_next(CrcInit, b);
        parse_phase = ST_LEN;
      end
      ST_LEN: begin
        fill = '0;
        lim  = (32'(max_len_r) > PayloadDepth) ? PayloadDepth : 32'(max_len_r);
        if (32'(b) > lim) begin
          parse_phase = ST_SYNC1;
        end else begin
          held_len    = b[LenW-1:0];
          run_crc     = crc_next(run_crc, b);
          parse_phase = (b == 0) ? ST_CHECK : ST_DATA;
        end
      end
      ST_DATA: begin
        if (fill < PayloadDepth) begin
          payload_mem[fill[AddrW-1:0]] = b;
        end
        run_crc = crc_next(run_crc, b);
        fill    = fill + LenW'(1);
        if (fill >= held_len) begin
          parse_phase = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (run_crc == b) begin
          if (held_len == 0) begin
            nb = '{held_type, '0, '0, '0, 1'b1};
            fresh_beats.push_back(nb);
          end else begin
            for (int k = 0; k < held_len && k < PayloadDepth; k++) begin
              nb.ftype = held_type;
              nb.flen  = held_len;
              nb.idx   = k[ByteIdxW-1:0];
              nb.pbyte = payload_mem[k[AddrW-1:0]];
              nb.last  = (k + 1 == held_len);
              fresh_beats.push_back(nb);
            end
          end
        end
        parse_phase = ST_SYNC1;
      end
      default: begin
        parse_phase = (b == sync_first_r) ? ST_SYNC2 : ST_SYNC1;
      end
    endcase
  endfunction

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      bad_beats++;
    end
  endfunction

  task automatic send_rx_byte(input logic [ByteW-1:0] b, input bit typed = 1'b0,
                              input frame_beat_t typed_beat = '0);
    int gap;
    gap = draw_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      rx_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    absorb_rx_byte(b);
    rx_bytes_sent++;
    if (typed) begin
      expected_beats.push_back(typed_beat);
    end else begin
      foreach (fresh_beats[k]) expected_beats.push_back(fresh_beats[k]);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_SYNC_FIRST:  sync_first_r  = v;
      CFG_SYNC_SECOND: sync_second_r = v;
      default:         max_len_r     = v[LenW-1:0];
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input int len, input bit crc_good);
    int unsigned lim;
    lim = (32'(max_len_r) > PayloadDepth) ? PayloadDepth : 32'(max_len_r);
    send_rx_byte(sync_first_r);
    send_rx_byte(sync_second_r);
    send_rx_byte(8'($urandom));
    send_rx_byte(8'(len));
    framed_bytes += 4;
    if (len <= lim) begin
      for (int k = 0; k < len; k++) send_rx_byte(8'($urandom));
      send_rx_byte(crc_good ? run_crc : run_crc ^ (8'h01 << $urandom_range(0, 7)));
      framed_bytes += len + 1;
    end
  endtask

  // Mostly well-formed frames; some noise, broken syncs, bad lengths and bad CRCs
  task automatic run_random(input int n_bytes);
    int start, r, len, lim;
    start = framed_bytes;
    while (framed_bytes - start < n_bytes) begin
      lim = (32'(max_len_r) > PayloadDepth) ? PayloadDepth : 32'(max_len_r);
      r   = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) send_rx_byte(8'($urandom));
      end else if (r < 14) begin
        send_rx_byte(sync_first_r);
        send_rx_byte(8'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = (r < 4) ? lim + 1 : $urandom_range(lim + 1, 255);
      end else if (r < 16) begin
        len = lim;
      end else if (r < 22) begin
        len = 0;
      end else begin
        len = $urandom_range(0, (lim < 8) ? lim : 8);
      end
      send_frame(len, $urandom_range(0, 9) != 0);
    end
  endtask

  // Bring the parser back to sync hunting, then let every result drain
  task automatic settle_block();
    while (parse_phase != ST_SYNC1) send_rx_byte(sync_first_r ^ 8'h01);
    @(negedge clk_i);
    rx_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // result receiver with random back-pressure
  initial begin
    int gap;
    frame_ch.ready = 1'b0;
    forever begin
      if (hold_sink_req) begin
        repeat (HOLD_CYC) begin
          @(negedge clk_i);
          frame_ch.ready <= 1'b0;
        end
        hold_sink_req = 1'b0;
        holds_done++;
      end
      gap = draw_gap(rx_calm);
      repeat (gap) begin
        @(negedge clk_i);
        frame_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      frame_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!frame_ch.valid);
    end
  end

  always @(posedge clk_i) begin : beat_check
    frame_beat_t want;
    if (rst_ni && frame_ch.valid && frame_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("stray result beat: type 0x%0h index %0d", frame_ch.frame_type,
               frame_ch.byte_index);
        bad_beats++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("frame_type",   want.ftype, frame_ch.frame_type);
        compare_field("frame_length", 8'(want.flen), 8'(frame_ch.frame_length));
        compare_field("byte_index",   8'(want.idx),  8'(frame_ch.byte_index));
        compare_field("payload_byte", want.pbyte, frame_ch.payload_byte);
        compare_field("last_byte",    8'(want.last), 8'(frame_ch.last_byte));
        beats_checked++;
        if (frame_ch.last_byte) frames_seen++;
      end
    end
  end

  initial begin
    dir_row_t         row;
    logic [ByteW-1:0] v;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_SYNC_FIRST;
    cfg_ch.data    = '0;
    hold_sink_req  = 1'b0;
    parse_phase    = ST_SYNC1;
    sync_first_r   = SyncFirstReset;
    sync_second_r  = SyncSecondReset;
    max_len_r      = MaxLengthReset;
    held_type      = '0;
    held_len       = '0;
    fill           = '0;
    run_crc        = CrcInit;
    rst_ni         = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        BYTE_CRC_OK:  v = run_crc;
        BYTE_CRC_BAD: v = run_crc ^ 8'h5A;
        default:      v = row.value;
      endcase
      send_rx_byte(v, row.typed, row.beat);
    end
    run_random(60);
    settle_block();

    // max length written with upper bits set: only the low six bits count
    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    write_reg(CFG_MAX_LENGTH, 8'hE0);
    send_frame(PayloadDepth, 1'b1);
    hold_sink_req = 1'b1;
    repeat (2) send_frame(PayloadDepth, 1'b1);
    run_random(60);
    settle_block();

    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    write_reg(CFG_MAX_LENGTH, 8'd0);
    run_random(30);
    settle_block();

    write_reg(CFG_SYNC_FIRST, 8'h7E);
    write_reg(CFG_SYNC_SECOND, 8'h7E);
    write_reg(CFG_MAX_LENGTH, 8'h7F);
    run_random(60);
    settle_block();

    write_reg(CFG_SYNC_FIRST, 8'($urandom));
    write_reg(CFG_SYNC_SECOND, 8'($urandom));
    write_reg(CFG_MAX_LENGTH, 8'($urandom_range(1, 31)));
    run_random(40);
    settle_block();

    $display("Sent %0d rx bytes under five register settings; checked %0d result beats",
             rx_bytes_sent, beats_checked);
    $display("from %0d frames, with %0d long receiver hold-off(s); %0d bad beats.",
             frames_seen, holds_done, bad_beats);
    if (bad_beats == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
